// ===== hdl/sss_pkg.sv =====
// shared types, constants and tables of the sphere section direction sampler
`default_nettype none
package sss_pkg;

   localparam int FRAC_BITS         = 16;
   localparam int OUT_W             = FRAC_BITS + 2;
   localparam int ELEM_W            = 20;
   localparam int ROW_W             = 3 * ELEM_W;
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int CORDIC_MAX        = 32;
   localparam int SQRT_STEPS        = 17;
   localparam int SQ_W              = 34;
   localparam int XY_W              = 34;
   localparam int Z_W               = 34;
   localparam int CSR_ADDR_W        = 6;
   localparam int CSR_DATA_W        = 64;

   localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sh026DD3B6A;
   localparam logic signed [OUT_W-1:0] ONE_Q      = 18'sd65536;

   localparam logic [ROW_W-1:0] ROW0_RST     = 60'h0000_0000_0001_0000;
   localparam logic [ROW_W-1:0] ROW1_RST     = 60'h0000_0010_0000_0000;
   localparam logic [ROW_W-1:0] ROW2_RST     = 60'h0100_0000_0000_0000;
   localparam logic signed [17:0] COS_START_RST = 18'sd65536;
   localparam logic signed [18:0] COS_SPAN_RST  = -19'sd131072;
   localparam logic [15:0] AZ_START_RST      = 16'd0;
   localparam logic [16:0] AZ_SPAN_RST       = 17'd65536;

   typedef enum logic [2:0] {
      REG_ROW0      = 3'd0,
      REG_ROW1      = 3'd1,
      REG_ROW2      = 3'd2,
      REG_COS_START = 3'd3,
      REG_COS_SPAN  = 3'd4,
      REG_AZ_START  = 3'd5,
      REG_AZ_SPAN   = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [2:0][ROW_W-1:0] rows;
      logic signed [17:0]    cos_start;
      logic signed [18:0]    cos_span;
      logic [15:0]           az_start;
      logic [16:0]           az_span;
   } cfg_type;

   typedef struct packed {
      logic [SQ_W-1:0]          rem;
      logic [SQRT_STEPS-1:0]    root;
      logic signed [XY_W-1:0]   x;
      logic signed [XY_W-1:0]   y;
      logic signed [Z_W-1:0]    z;
      logic                     flip;
      logic signed [OUT_W-1:0]  cz;
   } iter_type;

   function automatic logic [31:0] atan_turn(input logic [4:0] k);
      logic [31:0] a;
      case (k)
         5'd0:  a = 32'h20000000;
         5'd1:  a = 32'h12E4051D;
         5'd2:  a = 32'h09FB385B;
         5'd3:  a = 32'h051111D4;
         5'd4:  a = 32'h028B0D43;
         5'd5:  a = 32'h0145D7E1;
         5'd6:  a = 32'h00A2F61E;
         5'd7:  a = 32'h00517C55;
         5'd8:  a = 32'h0028BE53;
         5'd9:  a = 32'h00145F2F;
         5'd10: a = 32'h000A2F98;
         5'd11: a = 32'h000517CC;
         5'd12: a = 32'h00028BE6;
         5'd13: a = 32'h000145F3;
         5'd14: a = 32'h0000A2F9;
         5'd15: a = 32'h0000517C;
         5'd16: a = 32'h000028BE;
         5'd17: a = 32'h0000145F;
         5'd18: a = 32'h00000A2F;
         5'd19: a = 32'h00000517;
         5'd20: a = 32'h0000028B;
         5'd21: a = 32'h00000145;
         5'd22: a = 32'h000000A2;
         5'd23: a = 32'h00000051;
         5'd24: a = 32'h00000028;
         5'd25: a = 32'h00000014;
         5'd26: a = 32'h0000000A;
         5'd27: a = 32'h00000005;
         5'd28: a = 32'h00000002;
         5'd29: a = 32'h00000001;
         default: a = 32'h00000000;
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/sss_channels.sv =====
// valid/ready channel interfaces for sample requests and direction results
`default_nettype none
interface sss_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] uniform_polar;
   logic [15:0] uniform_azimuth;
   modport source (output valid, output uniform_polar, output uniform_azimuth, input ready);
   modport sink (input valid, input uniform_polar, input uniform_azimuth, output ready);
endinterface

interface sss_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [17:0] dir_x;
   logic signed [17:0] dir_y;
   logic signed [17:0] dir_z;
   modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
   modport sink (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface
`default_nettype wire

// ===== hdl/sss_csr.sv =====
// apb register file holding the rotation matrix and sampling ranges
`default_nettype none
module sss_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [sss_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [sss_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [sss_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                  csr_pready,
   output sss_pkg::cfg_type                      cfg
);
   sss_pkg::cfg_type cfg_ff;
   logic [2:0]       idx;
   logic             wr;

   assign idx        = csr_paddr[5:3];
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rows[0]   <= sss_pkg::ROW0_RST;
         cfg_ff.rows[1]   <= sss_pkg::ROW1_RST;
         cfg_ff.rows[2]   <= sss_pkg::ROW2_RST;
         cfg_ff.cos_start <= sss_pkg::COS_START_RST;
         cfg_ff.cos_span  <= sss_pkg::COS_SPAN_RST;
         cfg_ff.az_start  <= sss_pkg::AZ_START_RST;
         cfg_ff.az_span   <= sss_pkg::AZ_SPAN_RST;
      end else if (wr) begin
         unique case (idx)
            sss_pkg::REG_ROW0:      cfg_ff.rows[0]   <= csr_pwdata[59:0];
            sss_pkg::REG_ROW1:      cfg_ff.rows[1]   <= csr_pwdata[59:0];
            sss_pkg::REG_ROW2:      cfg_ff.rows[2]   <= csr_pwdata[59:0];
            sss_pkg::REG_COS_START: cfg_ff.cos_start <= csr_pwdata[17:0];
            sss_pkg::REG_COS_SPAN:  cfg_ff.cos_span  <= csr_pwdata[18:0];
            sss_pkg::REG_AZ_START:  cfg_ff.az_start  <= csr_pwdata[15:0];
            sss_pkg::REG_AZ_SPAN:   cfg_ff.az_span   <= csr_pwdata[16:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         sss_pkg::REG_ROW0:      csr_prdata = {4'd0, cfg_ff.rows[0]};
         sss_pkg::REG_ROW1:      csr_prdata = {4'd0, cfg_ff.rows[1]};
         sss_pkg::REG_ROW2:      csr_prdata = {4'd0, cfg_ff.rows[2]};
         sss_pkg::REG_COS_START: csr_prdata = {46'd0, cfg_ff.cos_start};
         sss_pkg::REG_COS_SPAN:  csr_prdata = {45'd0, cfg_ff.cos_span};
         sss_pkg::REG_AZ_START:  csr_prdata = {48'd0, cfg_ff.az_start};
         sss_pkg::REG_AZ_SPAN:   csr_prdata = {47'd0, cfg_ff.az_span};
         default:                csr_prdata = '0;
      endcase
   end
endmodule
`default_nettype wire

// ===== hdl/sss_front.sv =====
// front stages: input capture, polar cosine and azimuth, squared term and cordic setup
`default_nettype none
module sss_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              in_valid,
   input  wire logic [15:0]       in_polar,
   input  wire logic [15:0]       in_azimuth,
   input  sss_pkg::cfg_type       cfg,
   output logic                   out_valid,
   output sss_pkg::iter_type      out_data
);
   logic        va_ff;
   logic [15:0] up_ff, ua_ff;
   logic        vb_ff;
   logic signed [17:0] cz_ff, cz_in;
   logic [15:0] phase_ff, phase_in;
   logic        vc_ff;
   sss_pkg::iter_type data_ff, data_in;

   logic signed [35:0] cprod;
   logic signed [20:0] crnd;
   logic signed [20:0] csum;
   logic [32:0]        aprod;
   logic signed [35:0] sqr;
   logic [31:0]        turn, tshift, tturn;

   always_comb begin
      cprod = 36'(cfg.cos_span) * 36'($signed({1'b0, up_ff}));
      crnd  = 21'((cprod + 36'sd32768) >>> 16);
      csum  = 21'(cfg.cos_start) + crnd;
      if (csum > 21'sd65536) begin
         cz_in = sss_pkg::ONE_Q;
      end else if (csum < -21'sd65536) begin
         cz_in = -sss_pkg::ONE_Q;
      end else begin
         cz_in = csum[17:0];
      end
      aprod    = 33'(cfg.az_span) * 33'(ua_ff);
      phase_in = cfg.az_start + aprod[31:16];
   end

   always_comb begin
      sqr          = 36'(cz_ff) * 36'(cz_ff);
      data_in.rem  = 34'h1_0000_0000 - sqr[33:0];
      data_in.root = '0;
      turn         = {phase_ff, 16'd0};
      tshift       = turn + 32'h4000_0000;
      data_in.flip = tshift[31];
      tturn        = tshift[31] ? (turn ^ 32'h8000_0000) : turn;
      data_in.z    = 34'($signed(tturn));
      data_in.x    = sss_pkg::CORDIC_GAIN;
      data_in.y    = '0;
      data_in.cz   = cz_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (advance) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         up_ff    <= in_polar;
         ua_ff    <= in_azimuth;
         cz_ff    <= cz_in;
         phase_ff <= phase_in;
         data_ff  <= data_in;
      end
   end

   assign out_valid = vc_ff;
   assign out_data  = data_ff;
endmodule
`default_nettype wire

// ===== hdl/sss_iter.sv =====
// iteration pipeline: each stage does at most one square root bit and one cordic rotation
`default_nettype none
module sss_iter #(
   parameter int CORDIC_STAGES = sss_pkg::CORDIC_STAGES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              in_valid,
   input  sss_pkg::iter_type      in_data,
   output logic                   out_valid,
   output sss_pkg::iter_type      out_data
);
   localparam int N = (CORDIC_STAGES > sss_pkg::SQRT_STEPS) ? CORDIC_STAGES
                                                            : sss_pkg::SQRT_STEPS;

   sss_pkg::iter_type stage_ff [N];
   logic              valid_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      sss_pkg::iter_type src, nxt;
      logic              vsrc;
      logic [sss_pkg::SQ_W-1:0]        d;
      logic signed [sss_pkg::XY_W-1:0] dx, dy;
      logic signed [sss_pkg::Z_W-1:0]  da;

      if (k == 0) begin : g_first
         assign src  = in_data;
         assign vsrc = in_valid;
      end else begin : g_next
         assign src  = stage_ff[k-1];
         assign vsrc = valid_ff[k-1];
      end

      always_comb begin
         nxt = src;
         d   = '0;
         dx  = '0;
         dy  = '0;
         da  = '0;
         if (k < sss_pkg::SQRT_STEPS) begin
            d = ({{(sss_pkg::SQ_W-sss_pkg::SQRT_STEPS){1'b0}}, src.root}
                  << (sss_pkg::SQRT_STEPS - k))
                + ({{(sss_pkg::SQ_W-1){1'b0}}, 1'b1} << (2 * (sss_pkg::SQRT_STEPS - 1 - k)));
            if (src.rem >= d) begin
               nxt.rem  = src.rem - d;
               nxt.root = src.root
                        | ({{(sss_pkg::SQRT_STEPS-1){1'b0}}, 1'b1}
                           << (sss_pkg::SQRT_STEPS - 1 - k));
            end
         end
         if (k < CORDIC_STAGES) begin
            dx = src.y >>> k;
            dy = src.x >>> k;
            da = $signed({2'b00, sss_pkg::atan_turn(5'(k))});
            if (src.z >= 0) begin
               nxt.x = src.x - dx;
               nxt.y = src.y + dy;
               nxt.z = src.z - da;
            end else begin
               nxt.x = src.x + dx;
               nxt.y = src.y - dy;
               nxt.z = src.z + da;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= vsrc;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            stage_ff[k] <= nxt;
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_data  = stage_ff[N-1];
endmodule
`default_nettype wire

// ===== hdl/sss_back.sv =====
// back stages: polar sine scaling, matrix products, row sums and saturation
`default_nettype none
module sss_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              in_valid,
   input  sss_pkg::iter_type      in_data,
   input  sss_pkg::cfg_type       cfg,
   output logic                   out_valid,
   output logic signed [17:0]     out_x,
   output logic signed [17:0]     out_y,
   output logic signed [17:0]     out_z
);
   logic vd_ff, ve_ff, vf_ff, vg_ff;
   logic signed [49:0] p0_ff, p1_ff, p0_in, p1_in;
   logic signed [17:0] czd_ff;
   logic signed [19:0] v_ff [3];
   logic signed [19:0] v_in [3];
   logic signed [39:0] m_ff [3][3];
   logic signed [17:0] o_ff [3];
   logic signed [17:0] o_in [3];
   logic signed [sss_pkg::XY_W-1:0] cx, sy;
   logic signed [17:0] sp;
   logic signed [49:0] r0, r1;

   always_comb begin
      cx    = in_data.flip ? -in_data.x : in_data.x;
      sy    = in_data.flip ? -in_data.y : in_data.y;
      sp    = $signed({1'b0, in_data.root});
      p0_in = 50'(sp) * 50'($signed(cx[31:0]));
      p1_in = 50'(sp) * 50'($signed(sy[31:0]));
   end

   always_comb begin
      r0      = (p0_ff + 50'sd536870912) >>> 30;
      r1      = (p1_ff + 50'sd536870912) >>> 30;
      v_in[0] = r0[19:0];
      v_in[1] = r1[19:0];
      v_in[2] = 20'(czd_ff);
   end

   for (genvar r = 0; r < 3; r++) begin : g_row
      logic signed [41:0] acc;
      logic signed [25:0] rnd;
      always_comb begin
         acc = 42'(m_ff[r][0]) + 42'(m_ff[r][1]) + 42'(m_ff[r][2]);
         rnd = 26'((acc + 42'sd32768) >>> 16);
         if (rnd > 26'sd65536) begin
            o_in[r] = sss_pkg::ONE_Q;
         end else if (rnd < -26'sd65536) begin
            o_in[r] = -sss_pkg::ONE_Q;
         end else begin
            o_in[r] = rnd[17:0];
         end
      end
      for (genvar j = 0; j < 3; j++) begin : g_col
         always_ff @(posedge clock) begin
            if (advance) begin
               m_ff[r][j] <= 40'($signed(cfg.rows[r][sss_pkg::ELEM_W*j +: sss_pkg::ELEM_W]))
                             * 40'(v_ff[j]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
         vf_ff <= 1'b0;
         vg_ff <= 1'b0;
      end else if (advance) begin
         vd_ff <= in_valid;
         ve_ff <= vd_ff;
         vf_ff <= ve_ff;
         vg_ff <= vf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p0_ff  <= p0_in;
         p1_ff  <= p1_in;
         czd_ff <= in_data.cz;
         v_ff   <= v_in;
         o_ff   <= o_in;
      end
   end

   assign out_valid = vg_ff;
   assign out_x     = o_ff[0];
   assign out_y     = o_ff[1];
   assign out_z     = o_ff[2];
endmodule
`default_nettype wire

// ===== hdl/sphere_section_direction_sampler_core.sv =====
// pipeline: front stages, then iteration stages, then back stages
// throughput: one beat per cycle; the whole pipeline holds while a result beat waits
// the iteration depth is set by the 17-bit square root and the cordic stage count
// reset: synchronous, clears all stage valid bits and loads registers to defaults
// identity matrix, full sphere, full turn of azimuth
`default_nettype none
module sphere_section_direction_sampler_core #(
   parameter int CORDIC_STAGES = sss_pkg::CORDIC_STAGES_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   sss_req_if.sink                              req,
   sss_rsp_if.source                            rsp,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [sss_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [sss_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [sss_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                 csr_pready
);
   sss_pkg::cfg_type  cfg;
   sss_pkg::iter_type front_data, iter_data;
   logic              front_valid, iter_valid, advance;

   assign advance   = !rsp.valid || rsp.ready;
   assign req.ready = advance;

   sss_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sss_front u_front (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req.valid),
      .in_polar   (req.uniform_polar),
      .in_azimuth (req.uniform_azimuth),
      .cfg        (cfg),
      .out_valid  (front_valid),
      .out_data   (front_data)
   );

   sss_iter #(.CORDIC_STAGES(CORDIC_STAGES)) u_iter (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (iter_valid),
      .out_data  (iter_data)
   );

   sss_back u_back (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (iter_valid),
      .in_data   (iter_data),
      .cfg       (cfg),
      .out_valid (rsp.valid),
      .out_x     (rsp.dir_x),
      .out_y     (rsp.dir_y),
      .out_z     (rsp.dir_z)
   );
endmodule
`default_nettype wire

// ===== hdl/sss_checker.sv =====
// port-level checks of the sampler core and their binding
`default_nettype none
module sss_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic signed [17:0] rsp_dir_x,
   input wire logic signed [17:0] rsp_dir_y,
   input wire logic signed [17:0] rsp_dir_z
);
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dir_x) && $stable(rsp_dir_y)
                                 && $stable(rsp_dir_z))
      else $error("result beat changed while stalled");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not follow output space");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_dir_x <= 18'sd65536 && rsp_dir_x >= -18'sd65536
                 && rsp_dir_y <= 18'sd65536 && rsp_dir_y >= -18'sd65536
                 && rsp_dir_z <= 18'sd65536 && rsp_dir_z >= -18'sd65536)
      else $error("direction component outside unit range");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");
endmodule

bind sphere_section_direction_sampler_core sss_checker u_sss_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_dir_x (rsp.dir_x),
   .rsp_dir_y (rsp.dir_y),
   .rsp_dir_z (rsp.dir_z)
);
`default_nettype wire

// ===== sim/sphere_section_direction_sampler_core_tb.sv =====
// self-checking testbench of the sphere section direction sampler: directed and random samples
`default_nettype none
module sphere_section_direction_sampler_core_tb;

   typedef struct packed {
      logic [15:0] up;
      logic [15:0] ua;
   } sample_type;

   typedef struct packed {
      logic signed [17:0] x;
      logic signed [17:0] y;
      logic signed [17:0] z;
   } dir_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [sss_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [sss_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [sss_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   sss_req_if req ();
   sss_rsp_if rsp ();

   sphere_section_direction_sampler_core i_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // predictor copy of the registers
   logic [sss_pkg::ROW_W-1:0] m_rows [3];
   logic signed [17:0] m_cstart;
   logic signed [18:0] m_cspan;
   logic [15:0] m_azstart;
   logic [16:0] m_azspan;

   sample_type pending_samples[$];
   dir_type expected_dirs[$];
   int mismatches = 0;
   int send_idle = 26, recv_idle = 48;
   int hold_cycles = 0;
   bit pause_send = 1'b0;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic longint fshift(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint rshift(longint v, int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
   endfunction

   function automatic longint clamp_one(longint v);
      if (v > 65536) return 65536;
      if (v < -65536) return -65536;
      return v;
   endfunction

   function automatic longint floor_root(longint v);
      longint res = 0, b = longint'(1) <<< 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >>> 1) + b;
         end else begin
            res = res >>> 1;
         end
         b = b >>> 2;
      end
      return res;
   endfunction

   function automatic dir_type predict_direction(sample_type s);
      longint cz, sq, sp, x, y, z, dx, dy, acc, m;
      longint v [3];
      logic [31:0] turn;
      logic [15:0] phase;
      logic [33:0] prod;
      bit flip;
      dir_type d;
      cz = clamp_one(longint'(m_cstart) + rshift(longint'(m_cspan) * longint'(s.up), 16));
      sq = 64'sd4294967296 - cz * cz;
      if (sq < 0) sq = 0;
      sp = floor_root(sq);
      prod = 34'(m_azspan) * 34'(s.ua);
      phase = m_azstart + prod[31:16];
      turn = {phase, 16'h0};
      flip = 1'b0;
      if (turn + 32'h40000000 >= 32'h80000000) begin
         turn = turn - 32'h80000000;
         flip = 1'b1;
      end
      x = 64'sh26DD3B6A;
      y = 0;
      z = longint'(signed'(turn));
      for (int i = 0; i < sss_pkg::CORDIC_STAGES_DEF; i++) begin
         dx = fshift(y, i);
         dy = fshift(x, i);
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - longint'(atan_table(i));
         end else begin
            x = x + dx; y = y - dy; z = z + longint'(atan_table(i));
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      v[0] = rshift(sp * x, 30);
      v[1] = rshift(sp * y, 30);
      v[2] = cz;
      for (int r = 0; r < 3; r++) begin
         acc = 0;
         for (int j = 0; j < 3; j++) begin
            m = longint'(signed'(m_rows[r][20*j +: 20]));
            acc = acc + m * v[j];
         end
         acc = clamp_one(rshift(acc, 16));
         if (r == 0) d.x = acc[17:0];
         else if (r == 1) d.y = acc[17:0];
         else d.z = acc[17:0];
      end
      return d;
   endfunction

   function automatic logic [31:0] atan_table(int k);
      case (k)
         0: return 32'h20000000;  1: return 32'h12E4051D;  2: return 32'h09FB385B;
         3: return 32'h051111D4;  4: return 32'h028B0D43;  5: return 32'h0145D7E1;
         6: return 32'h00A2F61E;  7: return 32'h00517C55;  8: return 32'h0028BE53;
         9: return 32'h00145F2F; 10: return 32'h000A2F98; 11: return 32'h000517CC;
         12: return 32'h00028BE6; 13: return 32'h000145F3; 14: return 32'h0000A2F9;
         15: return 32'h0000517C; default: return 32'h0;
      endcase
   endfunction

   // driver
   initial begin
      req.valid = 1'b0;
      req.uniform_polar = '0;
      req.uniform_azimuth = '0;
      rsp.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || req.ready) begin
         if (pending_samples.size() > 0 && !pause_send &&
             $urandom_range(99) >= send_idle) begin
            sample_type s;
            s = pending_samples.pop_front();
            req.valid <= 1'b1;
            req.uniform_polar <= s.up;
            req.uniform_azimuth <= s.ua;
            expected_dirs.push_back(predict_direction(s));
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // receiver stall with an optional long hold-off
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= !reset && ($urandom_range(99) >= recv_idle);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_dirs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat %h %h %h", rsp.dir_x, rsp.dir_y,
                                           rsp.dir_z);
         end else begin
            dir_type e;
            e = expected_dirs.pop_front();
            if (e.x !== rsp.dir_x || e.y !== rsp.dir_y || e.z !== rsp.dir_z) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch exp %0d %0d %0d got %0d %0d %0d", e.x, e.y, e.z,
                           rsp.dir_x, rsp.dir_y, rsp.dir_z);
            end
         end
      end
   end

   task automatic write_reg(sss_pkg::reg_index_type idx, logic [63:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= sss_pkg::CSR_ADDR_W'(8 * idx);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         sss_pkg::REG_ROW0: m_rows[0] = value[59:0];
         sss_pkg::REG_ROW1: m_rows[1] = value[59:0];
         sss_pkg::REG_ROW2: m_rows[2] = value[59:0];
         sss_pkg::REG_COS_START: m_cstart = value[17:0];
         sss_pkg::REG_COS_SPAN: m_cspan = value[18:0];
         sss_pkg::REG_AZ_START: m_azstart = value[15:0];
         default: m_azspan = value[16:0];
      endcase
   endtask

   task automatic drain();
      while (pending_samples.size() > 0 || expected_dirs.size() > 0 || req.valid)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [19:0] rand_elem();
      case ($urandom_range(4))
         0: return 20'h10000;
         1: return 20'hF0000;
         2: return 20'h7FFFF;
         3: return 20'h80000;
         default: return 20'($signed($urandom_range(131072)) - 65536);
      endcase
   endfunction

   task automatic random_config(bit extreme);
      for (int r = 0; r < 3; r++)
         write_reg(sss_pkg::reg_index_type'(r), {$urandom, $urandom} ^
                   (extreme ? 64'h0 : {$urandom, $urandom}));
      for (int r = 0; r < 3; r++)
         write_reg(sss_pkg::reg_index_type'(r), {4'h0, rand_elem(), rand_elem(), rand_elem()});
      write_reg(sss_pkg::REG_COS_START,
                64'(extreme ? -65536 : $signed($urandom_range(131072)) - 65536));
      write_reg(sss_pkg::REG_COS_SPAN,
                64'(extreme ? 131072 : $signed($urandom_range(262144)) - 131072));
      write_reg(sss_pkg::REG_AZ_START, extreme ? 64'hFFFF : 64'($urandom_range(65535)));
      write_reg(sss_pkg::REG_AZ_SPAN, extreme ? 64'h0 : 64'($urandom_range(65536)));
   endtask

   task automatic queue_random(int n);
      sample_type s;
      for (int i = 0; i < n; i++) begin
         s.up = 16'($urandom);
         s.ua = 16'($urandom);
         pending_samples.push_back(s);
      end
   endtask

   initial begin
      sample_type s;
      m_rows[0] = sss_pkg::ROW0_RST; m_rows[1] = sss_pkg::ROW1_RST;
      m_rows[2] = sss_pkg::ROW2_RST;
      m_cstart = sss_pkg::COS_START_RST; m_cspan = sss_pkg::COS_SPAN_RST;
      m_azstart = sss_pkg::AZ_START_RST; m_azspan = sss_pkg::AZ_SPAN_RST;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      // directed corners under the reset setting
      for (int i = 0; i < 16; i++) begin
         s.up = (i % 4 == 0) ? 16'h0 : (i % 4 == 1) ? 16'hFFFF : (i % 4 == 2) ? 16'h8000 : 16'h4000;
         s.ua = (i < 4) ? 16'h0 : (i < 8) ? 16'hFFFF : (i < 12) ? 16'h4000 : 16'hC000;
         pending_samples.push_back(s);
      end
      drain();
      // out-of-range polar cosine, wrapping azimuth, extreme matrix
      write_reg(sss_pkg::REG_COS_START, 64'h10000);
      write_reg(sss_pkg::REG_COS_SPAN, 64'(131072));
      write_reg(sss_pkg::REG_AZ_START, 64'hFFFF);
      write_reg(sss_pkg::REG_AZ_SPAN, 64'h1FFFF);
      write_reg(sss_pkg::REG_ROW0, {4'hF, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF});
      write_reg(sss_pkg::REG_ROW1, {4'h0, 20'h80000, 20'h80000, 20'h80000});
      write_reg(sss_pkg::REG_ROW2, 64'h0);
      queue_random(8);
      drain();
      random_config(1'b1);
      queue_random(170);
      // long receiver hold-off while items keep coming
      hold_cycles = 200;
      drain();
      random_config(1'b0);
      send_idle = 48; recv_idle = 26;
      queue_random(180);
      drain();
      random_config(1'b0);
      send_idle = 0; recv_idle = 0;
      queue_random(180);
      drain();
      // sender pauses with beats in flight until every result is back
      send_idle = 20; recv_idle = 40;
      queue_random(20);
      repeat (10) @(posedge clock);
      pause_send = 1'b1;
      while (expected_dirs.size() > 0) @(posedge clock);
      pause_send = 1'b0;
      drain();
      if (mismatches == 0 && expected_dirs.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end
endmodule
`default_nettype wire
